/* sv/pfsa_pkg.sv */
// ----------------------------------------------------------------------------
// pfsa_pkg: shared types and constants of the pair force stress accumulator
// Sequencer states, register indexes, fixed-point limits and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package pfsa_pkg;

    // Default sizes
    localparam int POS_WIDTH_DEF = 32;
    localparam int ACC_WIDTH_DEF = 48;

    // Fixed-point limits
    localparam int REG_WIDTH = 31;
    localparam int Q_WIDTH   = 48;
    localparam int OP_WIDTH  = 64;
    localparam logic signed [Q_WIDTH-1:0] ONE_Q   = 48'sd65536;
    localparam logic signed [Q_WIDTH-1:0] MID_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic [32:0]               OFS_MAX = 33'h0_FFFF_FFFF;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF_SQ = 3'd0,
        CFG_CONTACT_R = 3'd1,
        CFG_INV_SIGMA = 3'd2,
        CFG_EPS_COEF  = 3'd3,
        CFG_PAIR_COEF = 3'd4,
        CFG_INV_MASS  = 3'd5
    } t_cfg_idx;

    // Register reset values
    localparam logic [REG_WIDTH-1:0] RST_CUTOFF_SQ = 31'd131072;
    localparam logic [REG_WIDTH-1:0] RST_CONTACT_R = 31'd393216;
    localparam logic [REG_WIDTH-1:0] RST_INV_SIGMA = 31'd81920;
    localparam logic [REG_WIDTH-1:0] RST_EPS_COEF  = 31'd65536000;
    localparam logic [REG_WIDTH-1:0] RST_PAIR_COEF = 31'd524288;
    localparam logic [REG_WIDTH-1:0] RST_INV_MASS  = 31'd65536;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SQY, S_SEL,
        S_T2, S_T3, S_SS,
        S_SQRT, S_U, S_UU, S_W2, S_W3, S_EU, S_F, S_DIV,
        S_FX, S_FY, S_AX, S_AY, S_SXX, S_SXY, S_SYX, S_SYY,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

/* sv/pfsa_in_if.sv */
// ----------------------------------------------------------------------------
// pfsa_in_if: pair input channel
// Valid/ready channel carrying one neighbor pair per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfsa_in_if #(
    parameter int POS_WIDTH = pfsa_pkg::POS_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [POS_WIDTH-1:0] x_i;
    logic signed [POS_WIDTH-1:0] y_i;
    logic signed [POS_WIDTH-1:0] x_j;
    logic signed [POS_WIDTH-1:0] y_j;
    logic                        ring_i;
    logic                        ring_j;
    logic                        is_self;
    logic                        last_pair;

    modport source (output valid, x_i, y_i, x_j, y_j, ring_i, ring_j, is_self, last_pair,
                    input ready);
    modport sink   (input valid, x_i, y_i, x_j, y_j, ring_i, ring_j, is_self, last_pair,
                    output ready);
endinterface

`default_nettype wire

/* sv/pfsa_out_if.sv */
// ----------------------------------------------------------------------------
// pfsa_out_if: result channel
// Valid/ready channel carrying the saturated sums of one target per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfsa_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] stress_xx;
    logic signed [31:0] stress_xy;
    logic signed [31:0] stress_yx;
    logic signed [31:0] stress_yy;

    modport source (output valid, accel_x, accel_y, stress_xx, stress_xy, stress_yx,
                    stress_yy, input ready);
    modport sink   (input valid, accel_x, accel_y, stress_xx, stress_xy, stress_yx,
                    stress_yy, output ready);
endinterface

`default_nettype wire

/* sv/pfsa_qmul.sv */
// ----------------------------------------------------------------------------
// pfsa_qmul: shared Q16.16 multiplier
// Sign-magnitude 64x64 product from one 32x32 multiplier, summing four partial products;
// scaled result saturates to the 48-bit internal range, raw low word kept.
// ----------------------------------------------------------------------------
`default_nettype none

module pfsa_qmul (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic signed [pfsa_pkg::OP_WIDTH-1:0]  i_a,
    input  wire logic signed [pfsa_pkg::OP_WIDTH-1:0]  i_b,
    output logic                                       o_done,
    output logic signed [pfsa_pkg::Q_WIDTH-1:0]        o_prod,
    output logic        [pfsa_pkg::OP_WIDTH-1:0]       o_raw
);
    localparam int W = pfsa_pkg::OP_WIDTH;

    logic [W-1:0]   r_ua, r_ub;
    logic           r_neg, r_busy, r_done;
    logic [1:0]     r_step;
    logic [2*W-1:0] r_acc;

    logic [31:0]    n_opa, n_opb;
    logic [63:0]    n_part;
    logic [2*W-1:0] n_shift;
    logic [2*W-17:0] n_q;
    logic [pfsa_pkg::Q_WIDTH-1:0] n_mag;

    // Partial product select: low/high halves by step
    always_comb begin
        n_opa  = r_step[1] ? r_ua[W-1:32] : r_ua[31:0];
        n_opb  = (r_step == 2'd1 || r_step == 2'd3) ? r_ub[W-1:32] : r_ub[31:0];
        n_part = n_opa * n_opb;
        case (r_step)
            2'd0:    n_shift = {64'd0, n_part};
            2'd3:    n_shift = {n_part, 64'd0};
            default: n_shift = {32'd0, n_part, 32'd0};
        endcase
    end

    // Control and accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= i_a[W-1] ? W'(-i_a) : W'(i_a);
            r_ub  <= i_b[W-1] ? W'(-i_b) : W'(i_b);
            r_neg <= i_a[W-1] ^ i_b[W-1];
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + n_shift;
        end
    end

    // Scale, saturate, apply sign
    always_comb begin
        n_q   = r_acc[2*W-1:16];
        n_mag = (n_q > (2*W-16)'(pfsa_pkg::MID_MAX)) ? pfsa_pkg::MID_MAX
                                                      : n_q[pfsa_pkg::Q_WIDTH-1:0];
        o_prod = r_neg ? -$signed(n_mag) : $signed(n_mag);
        o_raw  = r_acc[W-1:0];
        o_done = r_done;
    end

    // Checks
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy) && $past(r_step) == 2'd3)
        else $error("product done without full pass");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_step != 2'd0 |-> !i_start)
        else $error("multiplier restarted mid product");
    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_prod != -pfsa_pkg::MID_MAX - 48'sd1)
        else $error("product outside saturated range");

endmodule

`default_nettype wire

/* sv/pair_force_stress_accumulator_unit.sv */
// ----------------------------------------------------------------------------
// pair_force_stress_accumulator_unit: pair force and virial stress sums
//
// One beat on i_in brings a neighbor pair of the current target particle.
// Same-ring pairs inside the cutoff get the polynomial force, cross-ring
// pairs inside the contact shell get the contact force; the force adds to
// two acceleration sums and half the outer product is taken from four
// stress sums. On a beat with last_pair set, the sums go out on o_out as
// one beat, saturated to 32 bits, and are cleared.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// Pairs are taken one at a time; i_in.ready is high only in idle. Each product
// on the shared multiplier is issued, built from four partial products and
// returned as done; the square root and the divider work one bit at a time.
// The result register is loaded at the end of the pair's last cycle; if it
// still holds an untaken result, the unit waits and takes no pair.
// After reset all sums are zero and the registers hold their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_force_stress_accumulator_unit #(
    parameter int POS_WIDTH = pfsa_pkg::POS_WIDTH_DEF,
    parameter int ACC_WIDTH = pfsa_pkg::ACC_WIDTH_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    pfsa_in_if.sink                                      i_in,
    pfsa_out_if.source                                   o_out,
    input  wire logic                                    i_cfg_we,
    input  wire logic [pfsa_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [pfsa_pkg::REG_WIDTH-1:0]          i_cfg_data
);
    localparam int QW     = pfsa_pkg::Q_WIDTH;
    localparam int OW     = pfsa_pkg::OP_WIDTH;
    localparam int RW     = pfsa_pkg::REG_WIDTH;
    localparam int DIFF_W = (POS_WIDTH + 1 > 34) ? POS_WIDTH + 1 : 34;
    localparam int SW     = ((ACC_WIDTH > QW) ? ACC_WIDTH : QW) + 2;
    localparam logic signed [SW-1:0] ACC_MAX_X =
        {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] ACC_MIN_X =
        {{(SW-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};
    localparam logic signed [ACC_WIDTH-1:0] O32_MAX =
        {{(ACC_WIDTH-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] O32_MIN =
        {{(ACC_WIDTH-31){1'b1}}, {31{1'b0}}};

    // Saturating accumulate
    function automatic logic signed [ACC_WIDTH-1:0] f_sat_add(
        input logic signed [ACC_WIDTH-1:0] a, input logic signed [QW-1:0] d);
        logic signed [SW-1:0] s;
        s = SW'(a) + SW'(d);
        if (s > ACC_MAX_X)      f_sat_add = ACC_MAX_X[ACC_WIDTH-1:0];
        else if (s < ACC_MIN_X) f_sat_add = ACC_MIN_X[ACC_WIDTH-1:0];
        else                    f_sat_add = s[ACC_WIDTH-1:0];
    endfunction

    function automatic logic signed [31:0] f_out32(input logic signed [ACC_WIDTH-1:0] a);
        if (a > O32_MAX)      f_out32 = 32'sh7FFF_FFFF;
        else if (a < O32_MIN) f_out32 = 32'sh8000_0000;
        else                  f_out32 = a[31:0];
    endfunction

    // Configuration registers
    logic [RW-1:0] r_cutoff_sq, r_contact_r, r_inv_sigma, r_eps_coef, r_pair_coef, r_inv_mass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff_sq <= pfsa_pkg::RST_CUTOFF_SQ;
            r_contact_r <= pfsa_pkg::RST_CONTACT_R;
            r_inv_sigma <= pfsa_pkg::RST_INV_SIGMA;
            r_eps_coef  <= pfsa_pkg::RST_EPS_COEF;
            r_pair_coef <= pfsa_pkg::RST_PAIR_COEF;
            r_inv_mass  <= pfsa_pkg::RST_INV_MASS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pfsa_pkg::CFG_CUTOFF_SQ: r_cutoff_sq <= i_cfg_data;
                pfsa_pkg::CFG_CONTACT_R: r_contact_r <= i_cfg_data;
                pfsa_pkg::CFG_INV_SIGMA: r_inv_sigma <= i_cfg_data;
                pfsa_pkg::CFG_EPS_COEF:  r_eps_coef  <= i_cfg_data;
                pfsa_pkg::CFG_PAIR_COEF: r_pair_coef <= i_cfg_data;
                pfsa_pkg::CFG_INV_MASS:  r_inv_mass  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and datapath registers
    pfsa_pkg::t_state r_state, n_state;
    logic                        r_issued, r_last, r_same;
    logic signed [32:0]          r_dx, r_dy;
    logic [63:0]                 r_sqx;
    logic [64:0]                 r_sumsq;
    logic signed [50:0]          r_t;
    logic signed [QW-1:0]        r_tmp, r_u, r_w, r_s, r_fx, r_fy;
    logic [33:0]                 r_root;
    logic [37:0]                 r_rem;
    logic [65:0]                 r_sh;
    logic [5:0]                  r_cnt;
    logic [34:0]                 r_drem;
    logic [62:0]                 r_quo, r_num;
    logic                        r_fneg;
    logic signed [ACC_WIDTH-1:0] r_sum [0:5];
    logic                        r_ovalid;
    logic signed [31:0]          r_o [0:5];

    // Shared multiplier
    logic                  mul_start, mul_done, mul_op;
    logic signed [OW-1:0]  mul_a, mul_b;
    logic signed [QW-1:0]  mul_p;
    logic [OW-1:0]         mul_raw;

    pfsa_qmul u_qmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p),
        .o_raw   (mul_raw)
    );

    // Input offsets, clamped
    logic signed [DIFF_W-1:0] n_ddx, n_ddy, n_cdx, n_cdy;
    always_comb begin
        n_ddx = DIFF_W'(i_in.x_i) - DIFF_W'(i_in.x_j);
        n_ddy = DIFF_W'(i_in.y_i) - DIFF_W'(i_in.y_j);
        n_cdx = n_ddx;
        n_cdy = n_ddy;
        if (n_ddx > $signed(DIFF_W'(pfsa_pkg::OFS_MAX)))  n_cdx = DIFF_W'(pfsa_pkg::OFS_MAX);
        if (n_ddx < -$signed(DIFF_W'(pfsa_pkg::OFS_MAX))) n_cdx = -DIFF_W'(pfsa_pkg::OFS_MAX);
        if (n_ddy > $signed(DIFF_W'(pfsa_pkg::OFS_MAX)))  n_cdy = DIFF_W'(pfsa_pkg::OFS_MAX);
        if (n_ddy < -$signed(DIFF_W'(pfsa_pkg::OFS_MAX))) n_cdy = -DIFF_W'(pfsa_pkg::OFS_MAX);
    end

    // Multiplier operand select
    always_comb begin
        mul_op = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            pfsa_pkg::S_SQX: begin mul_a = OW'(r_dx); mul_b = OW'(r_dx); end
            pfsa_pkg::S_SQY: begin mul_a = OW'(r_dy); mul_b = OW'(r_dy); end
            pfsa_pkg::S_T2:  begin mul_a = OW'(r_t);  mul_b = OW'(r_t);  end
            pfsa_pkg::S_T3:  begin mul_a = OW'(r_tmp); mul_b = OW'(r_t); end
            pfsa_pkg::S_SS:  begin
                mul_a = $signed({{(OW-RW){1'b0}}, r_pair_coef});
                mul_b = OW'(r_tmp) - OW'(r_t);
            end
            pfsa_pkg::S_U: begin
                mul_a = $signed({{(OW-34){1'b0}}, r_root}) - $signed({{(OW-RW){1'b0}}, r_contact_r});
                mul_b = $signed({{(OW-RW){1'b0}}, r_inv_sigma});
            end
            pfsa_pkg::S_UU:  begin mul_a = OW'(r_u);   mul_b = OW'(r_u); end
            pfsa_pkg::S_W2:  begin mul_a = OW'(r_w);   mul_b = OW'(r_w); end
            pfsa_pkg::S_W3:  begin mul_a = OW'(r_tmp); mul_b = OW'(r_w); end
            pfsa_pkg::S_EU:  begin
                mul_a = $signed({{(OW-RW){1'b0}}, r_eps_coef});
                mul_b = OW'(r_u);
            end
            pfsa_pkg::S_F:   begin mul_a = OW'(r_w);  mul_b = OW'(r_tmp); end
            pfsa_pkg::S_FX:  begin mul_a = OW'(r_s);  mul_b = OW'(r_dx); end
            pfsa_pkg::S_FY:  begin mul_a = OW'(r_s);  mul_b = OW'(r_dy); end
            pfsa_pkg::S_AX:  begin mul_a = OW'(r_fx); mul_b = $signed({{(OW-RW){1'b0}}, r_inv_mass}); end
            pfsa_pkg::S_AY:  begin mul_a = OW'(r_fy); mul_b = $signed({{(OW-RW){1'b0}}, r_inv_mass}); end
            pfsa_pkg::S_SXX: begin mul_a = OW'(r_fx); mul_b = OW'(r_dx); end
            pfsa_pkg::S_SXY: begin mul_a = OW'(r_fy); mul_b = OW'(r_dx); end
            pfsa_pkg::S_SYX: begin mul_a = OW'(r_fx); mul_b = OW'(r_dy); end
            pfsa_pkg::S_SYY: begin mul_a = OW'(r_fy); mul_b = OW'(r_dy); end
            default: mul_op = 1'b0;
        endcase
        mul_start = mul_op && !r_issued;
    end

    // Square root and divider steps
    logic [37:0] n_rem;
    logic [37:0] n_trial;
    logic        n_rbit;
    logic [34:0] n_drem;
    logic        n_qbit;
    logic [62:0] n_quo;
    logic [QW-1:0] n_qsat;
    always_comb begin
        n_rem   = {r_rem[35:0], r_sh[65:64]};
        n_trial = {2'b00, r_root[33:0], 2'b01};
        n_rbit  = (n_rem >= n_trial);
        n_drem  = {r_drem[33:0], r_num[62]};
        n_qbit  = (n_drem >= {1'b0, r_root});
        n_quo   = {r_quo[61:0], n_qbit};
        n_qsat  = (n_quo > 63'(pfsa_pkg::MID_MAX)) ? pfsa_pkg::MID_MAX : n_quo[QW-1:0];
    end

    // Accumulator target and delta
    logic [2:0]           n_sel;
    logic                 n_acc;
    logic signed [QW-1:0] n_half, n_delta;
    always_comb begin
        n_acc = 1'b1;
        case (r_state)
            pfsa_pkg::S_AX:  n_sel = 3'd0;
            pfsa_pkg::S_AY:  n_sel = 3'd1;
            pfsa_pkg::S_SXX: n_sel = 3'd2;
            pfsa_pkg::S_SXY: n_sel = 3'd3;
            pfsa_pkg::S_SYX: n_sel = 3'd4;
            pfsa_pkg::S_SYY: n_sel = 3'd5;
            default: begin n_sel = 3'd0; n_acc = 1'b0; end
        endcase
        // halve toward zero: bias negatives by one before the arithmetic shift
        n_half  = (mul_p + $signed(QW'(mul_p < 0))) >>> 1;
        n_delta = (n_sel < 3'd2) ? mul_p : -n_half;
    end

    logic n_emit;
    assign n_emit = (r_state == pfsa_pkg::S_EMIT) && r_last && (!r_ovalid || o_out.ready);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfsa_pkg::S_IDLE:
                if (i_in.valid) n_state = i_in.is_self ? pfsa_pkg::S_EMIT : pfsa_pkg::S_SQX;
            pfsa_pkg::S_SQX: if (mul_done) n_state = pfsa_pkg::S_SQY;
            pfsa_pkg::S_SQY: if (mul_done) n_state = pfsa_pkg::S_SEL;
            pfsa_pkg::S_SEL:
                if (!r_same)                           n_state = pfsa_pkg::S_SQRT;
                else if (r_sumsq[64:16] < 49'(r_cutoff_sq)) n_state = pfsa_pkg::S_T2;
                else                                   n_state = pfsa_pkg::S_EMIT;
            pfsa_pkg::S_T2:  if (mul_done) n_state = pfsa_pkg::S_T3;
            pfsa_pkg::S_T3:  if (mul_done) n_state = pfsa_pkg::S_SS;
            pfsa_pkg::S_SS:  if (mul_done) n_state = pfsa_pkg::S_FX;
            pfsa_pkg::S_SQRT: if (r_cnt == 6'd32) n_state = pfsa_pkg::S_U;
            pfsa_pkg::S_U:
                if (mul_done)
                    n_state = (mul_p < pfsa_pkg::ONE_Q && r_root != '0) ? pfsa_pkg::S_UU
                                                                         : pfsa_pkg::S_EMIT;
            pfsa_pkg::S_UU:  if (mul_done) n_state = pfsa_pkg::S_W2;
            pfsa_pkg::S_W2:  if (mul_done) n_state = pfsa_pkg::S_W3;
            pfsa_pkg::S_W3:  if (mul_done) n_state = pfsa_pkg::S_EU;
            pfsa_pkg::S_EU:  if (mul_done) n_state = pfsa_pkg::S_F;
            pfsa_pkg::S_F:   if (mul_done) n_state = pfsa_pkg::S_DIV;
            pfsa_pkg::S_DIV: if (r_cnt == 6'd62) n_state = pfsa_pkg::S_FX;
            pfsa_pkg::S_FX:  if (mul_done) n_state = pfsa_pkg::S_FY;
            pfsa_pkg::S_FY:  if (mul_done) n_state = pfsa_pkg::S_AX;
            pfsa_pkg::S_AX:  if (mul_done) n_state = pfsa_pkg::S_AY;
            pfsa_pkg::S_AY:  if (mul_done) n_state = pfsa_pkg::S_SXX;
            pfsa_pkg::S_SXX: if (mul_done) n_state = pfsa_pkg::S_SXY;
            pfsa_pkg::S_SXY: if (mul_done) n_state = pfsa_pkg::S_SYX;
            pfsa_pkg::S_SYX: if (mul_done) n_state = pfsa_pkg::S_SYY;
            pfsa_pkg::S_SYY: if (mul_done) n_state = pfsa_pkg::S_EMIT;
            pfsa_pkg::S_EMIT:
                if (!r_last || n_emit) n_state = pfsa_pkg::S_IDLE;
            default: n_state = pfsa_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pfsa_pkg::S_IDLE;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < 6; k++) r_sum[k] <= '0;
        end else begin
            r_state <= n_state;
            if (mul_done)       r_issued <= 1'b0;
            else if (mul_start) r_issued <= 1'b1;
            if (n_acc && mul_done) r_sum[n_sel] <= f_sat_add(r_sum[n_sel], n_delta);
            if (n_emit) begin
                r_ovalid <= 1'b1;
                for (int k = 0; k < 6; k++) r_sum[k] <= '0;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (n_emit)
            for (int k = 0; k < 6; k++) r_o[k] <= f_out32(r_sum[k]);
        case (r_state)
            pfsa_pkg::S_IDLE: begin
                r_dx   <= n_cdx[32:0];
                r_dy   <= n_cdy[32:0];
                r_same <= (i_in.ring_i == i_in.ring_j);
                r_last <= i_in.last_pair;
            end
            pfsa_pkg::S_SQX: if (mul_done) r_sqx <= mul_raw;
            pfsa_pkg::S_SQY: if (mul_done) r_sumsq <= {1'b0, r_sqx} + {1'b0, mul_raw};
            pfsa_pkg::S_SEL: begin
                r_t    <= 51'sd131072 - $signed({2'b00, r_sumsq[64:16]});
                r_sh   <= {1'b0, r_sumsq};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            pfsa_pkg::S_T2:  if (mul_done) r_tmp <= mul_p;
            pfsa_pkg::S_T3:  if (mul_done) r_tmp <= mul_p;
            pfsa_pkg::S_SS:  if (mul_done) r_s <= mul_p;
            pfsa_pkg::S_SQRT: begin
                r_rem  <= n_rbit ? n_rem - n_trial : n_rem;
                r_root <= {r_root[32:0], n_rbit};
                r_sh   <= {r_sh[63:0], 2'b00};
                r_cnt  <= r_cnt + 6'd1;
            end
            pfsa_pkg::S_U:   if (mul_done) r_u <= mul_p;
            pfsa_pkg::S_UU:  if (mul_done) r_w <= pfsa_pkg::ONE_Q - mul_p;
            pfsa_pkg::S_W2:  if (mul_done) r_tmp <= mul_p;
            pfsa_pkg::S_W3:  if (mul_done) r_tmp <= mul_p;
            pfsa_pkg::S_EU:  if (mul_done) r_w <= mul_p;
            pfsa_pkg::S_F: if (mul_done) begin
                r_fneg <= mul_p < 0;
                r_num  <= {(mul_p < 0) ? 47'(-mul_p) : 47'(mul_p), 16'd0};
                r_drem <= '0;
                r_quo  <= '0;
                r_cnt  <= '0;
            end
            pfsa_pkg::S_DIV: begin
                r_drem <= n_qbit ? n_drem - {1'b0, r_root} : n_drem;
                r_quo  <= n_quo;
                r_num  <= {r_num[61:0], 1'b0};
                r_cnt  <= r_cnt + 6'd1;
                r_s    <= r_fneg ? -$signed(n_qsat) : $signed(n_qsat);
            end
            pfsa_pkg::S_FX:  if (mul_done) r_fx <= mul_p;
            pfsa_pkg::S_FY:  if (mul_done) r_fy <= mul_p;
            default: ;
        endcase
    end

    // Ports
    assign i_in.ready      = (r_state == pfsa_pkg::S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.accel_x   = r_o[0];
    assign o_out.accel_y   = r_o[1];
    assign o_out.stress_xx = r_o[2];
    assign o_out.stress_xy = r_o[3];
    assign o_out.stress_yx = r_o[4];
    assign o_out.stress_yy = r_o[5];

    // Checks
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_state != pfsa_pkg::S_IDLE)
        else $error("pair accepted without leaving idle");
    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_emit |=> r_sum[0] == '0 && r_sum[5] == '0 && r_ovalid)
        else $error("sums not cleared on emit");
    a_div_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pfsa_pkg::S_DIV |-> r_root != '0)
        else $error("divide by zero distance");
    a_mul_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> r_issued && mul_op)
        else $error("product returned to state that did not ask");

endmodule

`default_nettype wire
